[rtl/cwa_pkg.sv]
// ----------------------------------------------------------------------------
// Centered window average package
// Shared constants, widths and types for the centered window average block.
// ----------------------------------------------------------------------------
package cwa_pkg;

	// Largest window radius and sample width.
	localparam int MAX_RADIUS = 31;
	localparam int SAMPLE_W   = 32;

	// Width of the radius field on the configuration port.
	localparam int RADIUS_W = 5;

	// Width of the stored radius.
	localparam int RK_W = $clog2(MAX_RADIUS + 1);

	// Number of cells in the delay line: the 2k newest samples before the new one.
	localparam int LINE_DEPTH = 2 * MAX_RADIUS;
	localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	// Position count saturates here, which is enough for every decision.
	localparam int CNT_SAT = 2 * MAX_RADIUS + 1;
	localparam int CNT_W   = $clog2(CNT_SAT + 1);

	// Divisor 2k+1 and the sum of up to 2k+1 samples.
	localparam int DIVISOR_W = CNT_W;
	localparam int SUM_W     = SAMPLE_W + $clog2(CNT_SAT + 1);

	// One quotient bit per divider step.
	localparam int DIV_STEPS = SUM_W;
	localparam int DSTEP_W   = $clog2(DIV_STEPS);

	// Value given for an index whose window is incomplete.
	localparam logic [SAMPLE_W-1:0] FILL_VALUE = {SAMPLE_W{1'b1}};

	// Control of the delay line cells.
	typedef struct packed {
		logic shift;
		logic clear;
	} line_ctrl_t;

	// Sign-extend a sample to the width of the window sum.
	function automatic logic [SUM_W-1:0] widen(input logic [SAMPLE_W-1:0] v);
		return {{(SUM_W - SAMPLE_W){v[SAMPLE_W-1]}}, v};
	endfunction

endpackage

[rtl/cwa_if.sv]
// ----------------------------------------------------------------------------
// Centered window average channels
// Valid/ready channels for the sample stream and the result stream.
// ----------------------------------------------------------------------------

// Sample stream: one sample per beat, the last of a sequence flagged.
interface cwa_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [cwa_pkg::SAMPLE_W-1:0] sample;
	logic                               end_of_sequence;

	modport source (output valid, output sample, output end_of_sequence, input ready);
	modport sink   (input valid, input sample, input end_of_sequence, output ready);
endinterface

// Result stream: one window average per beat.
interface cwa_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [cwa_pkg::SAMPLE_W-1:0] average;
	logic                               full_res;
	logic                               last_result;

	modport source (output valid, output average, output full_res, output last_result,
		input ready);
	modport sink   (input valid, input average, input full_res, input last_result,
		output ready);
endinterface

[rtl/centered_window_average_top.sv]
// Path: a full-window result passes the bit-serial divider (38 divider steps)
//   before the result register; a fill result goes straight to the result register.
// Flow: no sample is taken until the last one's results are in the result register;
//   fill results at the end of a sequence leave one per cycle while out_ch.ready is high.
// Reset: radius 0, delay line and sums cleared; each radius write starts a
//   resum pass over the delay cells during which no sample is taken.
// ----------------------------------------------------------------------------
// Centered window average
// Averages each sample with its k neighbors on either side over a chain of
// delay cells, with -1 fill where the window is incomplete.
// ----------------------------------------------------------------------------
module centered_window_average_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cwa_pkg::RADIUS_W-1:0] cfg_wdata,
	cwa_in_if.sink                       in_ch,
	cwa_out_if.source                    out_ch
);

	// Controller states.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]                   state_q;
	logic [cwa_pkg::RK_W-1:0]     radius_q;
	logic [cwa_pkg::CNT_W-1:0]    pos_q;
	logic [cwa_pkg::CNT_W-1:0]    calc_cnt_q;
	logic [cwa_pkg::SUM_W-1:0]    acc_q;
	logic [cwa_pkg::SUM_W-1:0]    window_s1;
	logic                         main_q;
	logic                         full_q;
	logic                         eos_q;
	logic [cwa_pkg::RK_W-1:0]     fill_q;

	logic                         out_valid_q;
	logic [cwa_pkg::SAMPLE_W-1:0] out_avg_q;
	logic                         out_full_q;
	logic                         out_last_q;

	logic                         in_fire;
	logic [cwa_pkg::CNT_W-1:0]    k_ext;
	logic [cwa_pkg::CNT_W-1:0]    k2;
	logic [cwa_pkg::IDX_W-1:0]    tap_idx;
	logic [cwa_pkg::SAMPLE_W-1:0] tap;
	logic [cwa_pkg::SUM_W-1:0]    sample_w;
	logic [cwa_pkg::SUM_W-1:0]    window;
	logic                         reach_k;
	logic                         reach_2k;
	logic [cwa_pkg::CNT_W-1:0]    pos_inc;
	logic [cwa_pkg::RK_W-1:0]     fill_nxt;
	logic [cwa_pkg::RK_W-1:0]     radius_sat;
	cwa_pkg::line_ctrl_t          line_ctrl;
	logic                         div_start;
	logic                         div_done;
	logic [cwa_pkg::SAMPLE_W-1:0] div_quot;
	logic                         out_free;
	logic                         out_load;
	logic [cwa_pkg::RK_W-1:0]     rem_after;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;

	// Window geometry from the current radius.
	assign k_ext = cwa_pkg::CNT_W'(radius_q);
	assign k2    = cwa_pkg::CNT_W'({radius_q, 1'b0});

	// The resum pass walks the cells; a sample beat reads the cell leaving the window.
	assign tap_idx = (state_q == ST_CALC) ? calc_cnt_q[cwa_pkg::IDX_W-1:0]
		: cwa_pkg::IDX_W'(k2 - 1'b1);

	// New window sum and position decisions for the incoming sample.
	assign sample_w = cwa_pkg::widen(in_ch.sample);
	assign window   = acc_q + sample_w;
	assign reach_k  = pos_q >= k_ext;
	assign reach_2k = pos_q >= k2;
	assign pos_inc  = (pos_q == cwa_pkg::CNT_W'(cwa_pkg::CNT_SAT)) ? pos_q : pos_q + 1'b1;
	assign fill_nxt = !in_ch.end_of_sequence ? '0
		: (reach_k ? radius_q : cwa_pkg::RK_W'(pos_q + 1'b1));

	// Radius writes beyond the largest radius saturate.
	assign radius_sat = (32'(cfg_wdata) > 32'(cwa_pkg::MAX_RADIUS))
		? cwa_pkg::RK_W'(cwa_pkg::MAX_RADIUS) : cwa_pkg::RK_W'(cfg_wdata);

	assign line_ctrl.shift = in_fire;
	assign line_ctrl.clear = in_fire && in_ch.end_of_sequence;

	cwa_delay_line u_line (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (line_ctrl),
		.din     (in_ch.sample),
		.tap_idx (tap_idx),
		.tap     (tap)
	);

	assign div_start = in_fire && reach_k && reach_2k;

	cwa_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (window),
		.divisor  (cwa_pkg::DIVISOR_W'({radius_q, 1'b1})),
		.done     (div_done),
		.quotient (div_quot)
	);

	// The output register can take a result when empty or being drained.
	assign out_free  = !out_valid_q || out_ch.ready;
	assign out_load  = (state_q == ST_EMIT) && out_free;
	assign rem_after = main_q ? fill_q : fill_q - 1'b1;

	// Sequencing of samples, resum pass, division and result beats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			radius_q   <= '0;
			pos_q      <= '0;
			calc_cnt_q <= '0;
			acc_q      <= '0;
			main_q     <= 1'b0;
			full_q     <= 1'b0;
			eos_q      <= 1'b0;
			fill_q     <= '0;
		end else if (cfg_we) begin
			radius_q   <= radius_sat;
			calc_cnt_q <= '0;
			acc_q      <= '0;
			state_q    <= ST_CALC;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						main_q <= reach_k;
						full_q <= reach_2k;
						eos_q  <= in_ch.end_of_sequence;
						fill_q <= fill_nxt;
						if (in_ch.end_of_sequence || radius_q == '0) begin
							acc_q <= '0;
						end else begin
							acc_q <= window - cwa_pkg::widen(tap);
						end
						pos_q <= in_ch.end_of_sequence ? '0 : pos_inc;
						if (reach_k && reach_2k) begin
							state_q <= ST_DIV;
						end else if (reach_k || fill_nxt != '0) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_CALC: begin
					if (calc_cnt_q == k2) begin
						state_q <= ST_IDLE;
					end else begin
						acc_q      <= acc_q + cwa_pkg::widen(tap);
						calc_cnt_q <= calc_cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						if (main_q) begin
							main_q <= 1'b0;
						end else begin
							fill_q <= fill_q - 1'b1;
						end
						if (rem_after == '0) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Keep the window sum of the accepted sample; it is the result when the radius is 0.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			window_s1 <= window;
		end
	end

	// Result register: valid flag under reset, payload loaded on each beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (main_q && full_q) begin
				out_avg_q  <= (radius_q == '0) ? window_s1[cwa_pkg::SAMPLE_W-1:0] : div_quot;
				out_full_q <= 1'b1;
			end else begin
				out_avg_q  <= cwa_pkg::FILL_VALUE;
				out_full_q <= 1'b0;
			end
			out_last_q <= eos_q && (rem_after == '0);
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.average     = out_avg_q;
	assign out_ch.full_res    = out_full_q;
	assign out_ch.last_result = out_last_q;

endmodule

[rtl/cwa_cell.sv]
// ----------------------------------------------------------------------------
// Delay line cell
// Holds one sample, takes its neighbor's sample on a shift and offers its
// sample on the shared tap when selected.
// ----------------------------------------------------------------------------
module cwa_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cwa_pkg::line_ctrl_t          ctrl,
	input  logic [cwa_pkg::SAMPLE_W-1:0] din,
	input  logic                         sel,
	output logic [cwa_pkg::SAMPLE_W-1:0] dout,
	output logic [cwa_pkg::SAMPLE_W-1:0] tap
);

	logic [cwa_pkg::SAMPLE_W-1:0] sample_q;

	// Clear at the end of a sequence, otherwise shift when a sample enters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (ctrl.clear) begin
			sample_q <= '0;
		end else if (ctrl.shift) begin
			sample_q <= din;
		end
	end

	assign dout = sample_q;
	assign tap  = sel ? sample_q : '0;

endmodule

[rtl/cwa_delay_line.sv]
// ----------------------------------------------------------------------------
// Delay line
// A chain of sample cells, newest first, with one selectable read tap.
// ----------------------------------------------------------------------------
module cwa_delay_line (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cwa_pkg::line_ctrl_t          ctrl,
	input  logic [cwa_pkg::SAMPLE_W-1:0] din,
	input  logic [cwa_pkg::IDX_W-1:0]    tap_idx,
	output logic [cwa_pkg::SAMPLE_W-1:0] tap
);

	logic [cwa_pkg::SAMPLE_W-1:0] chain [cwa_pkg::LINE_DEPTH];
	logic [cwa_pkg::SAMPLE_W-1:0] taps  [cwa_pkg::LINE_DEPTH];

	// Each cell takes the sample of the cell before it; the first takes the input.
	for (genvar g = 0; g < cwa_pkg::LINE_DEPTH; g++) begin : g_cell
		logic [cwa_pkg::SAMPLE_W-1:0] cell_din;

		if (g == 0) begin : g_head
			assign cell_din = din;
		end else begin : g_body
			assign cell_din = chain[g-1];
		end

		cwa_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.din    (cell_din),
			.sel    (tap_idx == cwa_pkg::IDX_W'(g)),
			.dout   (chain[g]),
			.tap    (taps[g])
		);
	end

	// Only the selected cell drives a nonzero tap, so the taps combine by OR.
	always_comb begin
		tap = '0;
		for (int n = 0; n < cwa_pkg::LINE_DEPTH; n++) begin
			tap = tap | taps[n];
		end
	end

endmodule

[rtl/cwa_divider.sv]
// ----------------------------------------------------------------------------
// Window sum divider
// Restoring divider, one quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module cwa_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cwa_pkg::SUM_W-1:0]     dividend,
	input  logic [cwa_pkg::DIVISOR_W-1:0] divisor,
	output logic                          done,
	output logic [cwa_pkg::SAMPLE_W-1:0]  quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [cwa_pkg::DSTEP_W-1:0]   step_q;
	logic [cwa_pkg::SUM_W-1:0]     work_q;
	logic [cwa_pkg::DIVISOR_W-1:0] rem_q;
	logic [cwa_pkg::DIVISOR_W-1:0] dvs_q;
	logic                          neg_q;

	logic [cwa_pkg::DIVISOR_W:0]   trial;
	logic [cwa_pkg::DIVISOR_W:0]   diff;
	logic                          fits;
	logic [cwa_pkg::DIVISOR_W-1:0] rem_nxt;
	logic [cwa_pkg::SUM_W-1:0]     magnitude;
	logic [cwa_pkg::SAMPLE_W-1:0]  quot_mag;

	// Magnitude of the signed dividend.
	assign magnitude = dividend[cwa_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;

	// Bring down the next dividend bit and try to subtract the divisor.
	assign trial   = {rem_q, work_q[cwa_pkg::SUM_W-1]};
	assign diff    = trial - {1'b0, dvs_q};
	assign fits    = trial >= {1'b0, dvs_q};
	assign rem_nxt = fits ? diff[cwa_pkg::DIVISOR_W-1:0] : trial[cwa_pkg::DIVISOR_W-1:0];

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == cwa_pkg::DSTEP_W'(cwa_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend bits shift out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= magnitude;
			rem_q  <= '0;
			dvs_q  <= divisor;
			neg_q  <= dividend[cwa_pkg::SUM_W-1];
		end else if (busy_q) begin
			work_q <= {work_q[cwa_pkg::SUM_W-2:0], fits};
			rem_q  <= rem_nxt;
		end
	end

	assign quot_mag = work_q[cwa_pkg::SAMPLE_W-1:0];
	assign quotient = neg_q ? (~quot_mag + 1'b1) : quot_mag;
	assign done     = done_q;

endmodule
